/* rtl/mcgd_pkg.sv */
// Package for the mouse click gesture detector.
// Types, event codes and sizes shared by the lane, merge and top-level files.
// No dependencies.
`default_nettype none

package mcgd_pkg;

    localparam int NUM_BUTTONS = 4;
    localparam int NSLOT       = NUM_BUTTONS + 1;   // move/drag slot, then one per button
    localparam int SEL_W       = $clog2(NSLOT);
    localparam int BTN_W       = 2;
    localparam int POS_W       = 16;
    localparam int DELTA_W     = 17;
    localparam int WIN_W       = 8;
    localparam int EV_W        = 3;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 8'd15;

    localparam logic [EV_W-1:0] EV_MOVE    = 3'd0;
    localparam logic [EV_W-1:0] EV_DRAG    = 3'd1;
    localparam logic [EV_W-1:0] EV_PRESS   = 3'd2;
    localparam logic [EV_W-1:0] EV_RELEASE = 3'd3;
    localparam logic [EV_W-1:0] EV_CLICK   = 3'd4;
    localparam logic [EV_W-1:0] EV_DOUBLE  = 3'd5;

    // act low means the timer is idle
    typedef struct packed {
        logic             act;
        logic [WIN_W-1:0] cnt;
    } timer_t;

    typedef struct packed {
        logic            ev_valid;
        logic [EV_W-1:0] ev_code;
        timer_t          press_next;
        timer_t          click_next;
    } lane_out_t;

    // events found for one item, one slot each
    typedef struct packed {
        logic [NSLOT-1:0]            mask;
        logic [NSLOT-1:0][EV_W-1:0]  code;
        logic signed [DELTA_W-1:0]   dx;
        logic signed [DELTA_W-1:0]   dy;
    } list_t;

endpackage

`default_nettype wire

/* rtl/mouse_click_gesture_detector_unit.sv */
// Top level of the mouse click gesture detector: poll state, one lane per
// button, move detection and the merge stage. Depends on mcgd_pkg,
// mcgd_lane and mcgd_merge.
//
//  channel | ports                                   | dir | handshake
//  poll    | s_buttons s_pos_x s_pos_y               | in  | s_valid / s_ready
//  event   | m_event_res m_button m_delta_x/y m_last | out | m_valid / m_ready
//  config  | cfg_wdata (click_window)                | in  | cfg_we, no wait
//
// A poll is absorbed into the merge stage's event list when accepted; its events
// leave one per cycle while m_ready allows, and a poll with no events sends none.
// The next poll enters in the cycle its predecessor's final event moves into
// the output register, as the merge stage decides.
// Reset is synchronous and clears all poll state, timers and click_window (15).
// Stalls on m_ready hold the output register and back up into s_ready.
`default_nettype none

module mouse_click_gesture_detector_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [mcgd_pkg::WIN_W-1:0]        cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [mcgd_pkg::NUM_BUTTONS-1:0]  s_buttons,
    input  wire logic signed [mcgd_pkg::POS_W-1:0] s_pos_x,
    input  wire logic signed [mcgd_pkg::POS_W-1:0] s_pos_y,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [mcgd_pkg::EV_W-1:0]              m_event_res,
    output logic [mcgd_pkg::BTN_W-1:0]             m_button,
    output logic signed [mcgd_pkg::DELTA_W-1:0]    m_delta_x,
    output logic signed [mcgd_pkg::DELTA_W-1:0]    m_delta_y,
    output logic                                   m_last
);

    logic [mcgd_pkg::WIN_W-1:0]        window_reg;
    logic [mcgd_pkg::NUM_BUTTONS-1:0]  prev_buttons_reg;
    logic signed [mcgd_pkg::POS_W-1:0] prev_x_reg, prev_y_reg;
    mcgd_pkg::timer_t                  press_reg [mcgd_pkg::NUM_BUTTONS];
    mcgd_pkg::timer_t                  click_reg [mcgd_pkg::NUM_BUTTONS];
    mcgd_pkg::lane_out_t               lane_out  [mcgd_pkg::NUM_BUTTONS];
    mcgd_pkg::list_t                   list_next;
    logic                              accept;

    assign accept = s_valid && s_ready;

    for (genvar g = 0; g < mcgd_pkg::NUM_BUTTONS; g++) begin : g_lane
        mcgd_lane u_lane (
            .was       (prev_buttons_reg[g]),
            .now       (s_buttons[g]),
            .window    (window_reg),
            .press_cur (press_reg[g]),
            .click_cur (click_reg[g]),
            .lane_out  (lane_out[g])
        );
    end

    always_comb begin
        list_next.mask[0] = (s_pos_x != prev_x_reg) || (s_pos_y != prev_y_reg);
        list_next.code[0] = s_buttons[0] ? mcgd_pkg::EV_DRAG : mcgd_pkg::EV_MOVE;
        list_next.dx      = {s_pos_x[mcgd_pkg::POS_W-1], s_pos_x}
                          - {prev_x_reg[mcgd_pkg::POS_W-1], prev_x_reg};
        list_next.dy      = {s_pos_y[mcgd_pkg::POS_W-1], s_pos_y}
                          - {prev_y_reg[mcgd_pkg::POS_W-1], prev_y_reg};
        for (int i = 0; i < mcgd_pkg::NUM_BUTTONS; i++) begin
            list_next.mask[i+1] = lane_out[i].ev_valid;
            list_next.code[i+1] = lane_out[i].ev_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg       <= mcgd_pkg::WINDOW_RESET;
            prev_buttons_reg <= '0;
            prev_x_reg       <= '0;
            prev_y_reg       <= '0;
            for (int i = 0; i < mcgd_pkg::NUM_BUTTONS; i++) begin
                press_reg[i] <= '0;
                click_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) window_reg <= cfg_wdata;
            if (accept) begin
                prev_buttons_reg <= s_buttons;
                prev_x_reg       <= s_pos_x;
                prev_y_reg       <= s_pos_y;
                for (int i = 0; i < mcgd_pkg::NUM_BUTTONS; i++) begin
                    press_reg[i] <= lane_out[i].press_next;
                    click_reg[i] <= lane_out[i].click_next;
                end
            end
        end
    end

    mcgd_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (accept),
        .list_in     (list_next),
        .load_ok     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_event_res (m_event_res),
        .m_button    (m_button),
        .m_delta_x   (m_delta_x),
        .m_delta_y   (m_delta_y),
        .m_last      (m_last)
    );

`ifndef ASSERT_OFF
    a_move_no_button: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res == mcgd_pkg::EV_MOVE || m_event_res == mcgd_pkg::EV_DRAG)
        |-> m_button == '0)
        else $error("move/drag item carries a button index");

    a_button_no_delta: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !(m_event_res == mcgd_pkg::EV_MOVE || m_event_res == mcgd_pkg::EV_DRAG)
        |-> m_delta_x == '0 && m_delta_y == '0)
        else $error("button item carries a delta");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_event_res <= mcgd_pkg::EV_DOUBLE)
        else $error("undefined event code");

    a_move_has_delta: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res == mcgd_pkg::EV_MOVE || m_event_res == mcgd_pkg::EV_DRAG)
        |-> m_delta_x != '0 || m_delta_y != '0)
        else $error("move/drag item without movement");
`endif

endmodule

`default_nettype wire

/* rtl/mcgd_lane.sv */
// One button lane of the gesture detector: ticks both timers and classifies
// a level change. Purely combinational; depends on mcgd_pkg.
`default_nettype none

module mcgd_lane (
    input  wire logic                      was,
    input  wire logic                      now,
    input  wire logic [mcgd_pkg::WIN_W-1:0] window,
    input  wire mcgd_pkg::timer_t          press_cur,
    input  wire mcgd_pkg::timer_t          click_cur,
    output mcgd_pkg::lane_out_t            lane_out
);

    mcgd_pkg::timer_t press_tk;
    mcgd_pkg::timer_t click_tk;
    logic [mcgd_pkg::WIN_W:0] press_sum;
    logic [mcgd_pkg::WIN_W:0] click_sum;

    // timer counts up and falls idle once past the window
    always_comb begin
        press_sum = {1'b0, press_cur.cnt} + 9'd1;
        click_sum = {1'b0, click_cur.cnt} + 9'd1;
        press_tk.act = press_cur.act && (press_sum <= {1'b0, window});
        press_tk.cnt = press_sum[mcgd_pkg::WIN_W-1:0];
        click_tk.act = click_cur.act && (click_sum <= {1'b0, window});
        click_tk.cnt = click_sum[mcgd_pkg::WIN_W-1:0];
    end

    always_comb begin
        lane_out.ev_valid   = (was != now);
        lane_out.ev_code    = mcgd_pkg::EV_PRESS;
        lane_out.press_next = press_tk;
        lane_out.click_next = click_tk;
        if (was != now) begin
            if (was) begin
                if (click_tk.act) begin
                    lane_out.ev_code        = mcgd_pkg::EV_DOUBLE;
                    lane_out.click_next.act = 1'b0;
                    lane_out.press_next.act = 1'b0;
                end else if (press_tk.act) begin
                    lane_out.ev_code        = mcgd_pkg::EV_CLICK;
                    lane_out.click_next.act = 1'b1;
                    lane_out.click_next.cnt = '0;
                    lane_out.press_next.act = 1'b0;
                end else begin
                    lane_out.ev_code = mcgd_pkg::EV_RELEASE;
                end
            end else begin
                lane_out.ev_code        = mcgd_pkg::EV_PRESS;
                lane_out.press_next.act = 1'b1;
                lane_out.press_next.cnt = '0;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/mcgd_merge.sv */
// Merge stage: holds the event list of one item and sends its events in
// slot order through an output register. Depends on mcgd_pkg.
`default_nettype none

module mcgd_merge (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              load,
    input  wire mcgd_pkg::list_t                   list_in,
    output logic                                   load_ok,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [mcgd_pkg::EV_W-1:0]              m_event_res,
    output logic [mcgd_pkg::BTN_W-1:0]             m_button,
    output logic signed [mcgd_pkg::DELTA_W-1:0]    m_delta_x,
    output logic signed [mcgd_pkg::DELTA_W-1:0]    m_delta_y,
    output logic                                   m_last
);

    logic [mcgd_pkg::NSLOT-1:0]                 mask_reg, mask_next;
    logic [mcgd_pkg::NSLOT-1:0][mcgd_pkg::EV_W-1:0] code_reg;
    logic signed [mcgd_pkg::DELTA_W-1:0]        dx_reg, dy_reg;
    logic [mcgd_pkg::SEL_W-1:0]                 sel;
    logic [mcgd_pkg::NSLOT-1:0]                 rest;
    logic                                       out_free, move;

    always_comb begin
        sel = '0;
        for (int i = mcgd_pkg::NSLOT - 1; i >= 0; i--) begin
            if (mask_reg[i]) sel = mcgd_pkg::SEL_W'(i);
        end
    end

    always_comb begin
        rest      = mask_reg;
        rest[sel] = 1'b0;
        out_free  = !m_valid || m_ready;
        move      = out_free && (mask_reg != '0);
        // next item may enter when the list is empty or as the last pending event leaves
        load_ok   = (mask_reg == '0) || (move && (rest == '0));
        if (load) begin
            mask_next = list_in.mask;
        end else if (move) begin
            mask_next = rest;
        end else begin
            mask_next = mask_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
            m_valid  <= 1'b0;
        end else begin
            mask_reg <= mask_next;
            if (move) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            code_reg <= list_in.code;
            dx_reg   <= list_in.dx;
            dy_reg   <= list_in.dy;
        end
        if (move) begin
            m_event_res <= code_reg[sel];
            m_last      <= (rest == '0);
            if (sel == '0) begin
                m_button  <= '0;
                m_delta_x <= dx_reg;
                m_delta_y <= dy_reg;
            end else begin
                m_button  <= mcgd_pkg::BTN_W'(sel - 1'b1);
                m_delta_x <= '0;
                m_delta_y <= '0;
            end
        end
    end

endmodule

`default_nettype wire
